### rtl/core/gcc_pkg.sv
// shared constants and types for the grid cell corner point block
package gcc_pkg;
	localparam int CELL_W = 30;
	localparam int PT_W   = 30;
	localparam int CFG_W  = 11;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int BPS    = 5;

	typedef enum logic [1:0] {
		REG_POINTS_X = 2'd0,
		REG_POINTS_Y = 2'd1,
		REG_POINTS_Z = 2'd2
	} reg_idx_t;
endpackage

### rtl/core/gcc_ifs.sv
// valid/ready channel interfaces for cell numbers and corner points
interface gcc_cell_if;
	import gcc_pkg::*;
	logic              valid;
	logic              ready;
	logic [CELL_W-1:0] cell_number;
	modport source (output valid, output cell_number, input ready);
	modport sink (input valid, input cell_number, output ready);
endinterface

interface gcc_corner_if;
	import gcc_pkg::*;
	logic            valid;
	logic            ready;
	logic [PT_W-1:0] point_index;
	logic            last_corner;
	logic            bad_cell;
	modport source (output valid, output point_index, output last_corner, output bad_cell,
		input ready);
	modport sink (input valid, input point_index, input last_corner, input bad_cell,
		output ready);
endinterface

### rtl/core/gcc_cfg.sv
// apb register file holding the grid point counts
module gcc_cfg #(
	parameter int MAX_POINTS_PER_AXIS = 1024,
	parameter int PW = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gcc_pkg::ADDR_W-1:0] paddr,
	input  logic [gcc_pkg::DATA_W-1:0] pwdata,
	output logic [gcc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output logic [PW-1:0]              dim_x,
	output logic [PW-1:0]              dim_y,
	output logic [PW-1:0]              dim_z,
	output logic [gcc_pkg::PT_W-1:0]   plane
);
	import gcc_pkg::*;

	logic [PW-1:0]    px_q, py_q, pz_q;
	logic [PT_W-1:0]  plane_q;
	logic [31:0]      wv;
	logic [PW-1:0]    nv;
	logic             wr;
	logic [2*PW-1:0]  prod;
	reg_idx_t         idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel & penable & pwrite;

	// saturate to the axis limit, zero means keep
	always_comb begin
		wv = 32'(pwdata[CFG_W-1:0]);
		if (wv > 32'(MAX_POINTS_PER_AXIS))
			wv = 32'(MAX_POINTS_PER_AXIS);
		nv = PW'(wv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= PW'(1);
			py_q <= PW'(1);
			pz_q <= PW'(1);
		end else if (wr && wv != 32'd0) begin
			case (idx)
				REG_POINTS_X: px_q <= nv;
				REG_POINTS_Y: py_q <= nv;
				REG_POINTS_Z: pz_q <= nv;
				default: ;
			endcase
		end
	end

	assign prod = px_q * py_q;

	always_ff @(posedge clk) begin
		plane_q <= PT_W'(prod);
	end

	always_comb begin
		case (idx)
			REG_POINTS_X: prdata = DATA_W'(px_q);
			REG_POINTS_Y: prdata = DATA_W'(py_q);
			REG_POINTS_Z: prdata = DATA_W'(pz_q);
			default:      prdata = '0;
		endcase
	end

	assign dim_x = px_q;
	assign dim_y = py_q;
	assign dim_z = pz_q;
	assign plane = plane_q;
endmodule

### rtl/core/gcc_div.sv
// pipelined restoring divider splitting a cell number over three axes
module gcc_div #(
	parameter int DW = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [gcc_pkg::CELL_W-1:0] cell_no,
	input  logic [DW-1:0]              d_x,
	input  logic [DW-1:0]              d_y,
	input  logic [DW-1:0]              d_z,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [DW-1:0]              lo_x,
	output logic [DW-1:0]              lo_y,
	output logic [DW-1:0]              lo_z,
	output logic                       bad
);
	import gcc_pkg::*;

	localparam int NST = (3 * CELL_W) / BPS;

	logic [DW-1:0]     rem_s [NST];
	logic [CELL_W-1:0] quo_s [NST];
	logic [DW-1:0]     lx_s  [NST];
	logic [DW-1:0]     ly_s  [NST];
	logic              v_s   [NST];
	logic [DW-1:0]     nrem  [NST];
	logic [CELL_W-1:0] nquo  [NST];
	logic [DW-1:0]     nlx   [NST];
	logic [DW-1:0]     nly   [NST];
	logic              rdy   [NST+1];

	// each stage takes BPS quotient bits; remainders hand over at axis boundaries
	always_comb begin
		logic [DW-1:0]     r, lx, ly, dsel;
		logic [CELL_W-1:0] q;
		logic [DW:0]       t;
		logic              ge;
		int                s;
		for (int k = 0; k < NST; k++) begin
			r  = (k == 0) ? '0      : rem_s[(k == 0) ? 0 : k-1];
			q  = (k == 0) ? cell_no : quo_s[(k == 0) ? 0 : k-1];
			lx = (k == 0) ? '0      : lx_s[(k == 0) ? 0 : k-1];
			ly = (k == 0) ? '0      : ly_s[(k == 0) ? 0 : k-1];
			for (int j = 0; j < BPS; j++) begin
				s = k * BPS + j;
				if (s % CELL_W == 0 && s != 0) begin
					if (s / CELL_W == 1)
						lx = r;
					else
						ly = r;
					r = '0;
				end
				dsel = (s / CELL_W == 0) ? d_x : ((s / CELL_W == 1) ? d_y : d_z);
				t    = {r, q[CELL_W-1]};
				ge   = (t >= {1'b0, dsel});
				if (ge)
					t = t - {1'b0, dsel};
				r = t[DW-1:0];
				q = {q[CELL_W-2:0], ge};
			end
			nrem[k] = r;
			nquo[k] = q;
			nlx[k]  = lx;
			nly[k]  = ly;
		end
	end

	always_comb begin
		rdy[NST] = out_ready;
		for (int k = NST - 1; k >= 0; k--)
			rdy[k] = !v_s[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++)
				v_s[k] <= 1'b0;
		end else begin
			for (int k = 0; k < NST; k++)
				if (rdy[k])
					v_s[k] <= (k == 0) ? in_valid : v_s[(k == 0) ? 0 : k-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NST; k++) begin
			if (rdy[k]) begin
				rem_s[k] <= nrem[k];
				quo_s[k] <= nquo[k];
				lx_s[k]  <= nlx[k];
				ly_s[k]  <= nly[k];
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = v_s[NST-1];
	assign lo_x      = lx_s[NST-1];
	assign lo_y      = ly_s[NST-1];
	assign lo_z      = rem_s[NST-1];
	assign bad       = (quo_s[NST-1] != '0);
endmodule

### rtl/core/gcc_corner.sv
// corner index arithmetic and serialiser of the 1, 2, 4 or 8 corners
module gcc_corner #(
	parameter int DW = 10,
	parameter int PW = 11
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [DW-1:0]            lo_x,
	input  logic [DW-1:0]            lo_y,
	input  logic [DW-1:0]            lo_z,
	input  logic                     bad,
	input  logic [PW-1:0]            dim_x,
	input  logic [PW-1:0]            dim_y,
	input  logic [PW-1:0]            dim_z,
	input  logic [gcc_pkg::PT_W-1:0] plane,
	gcc_corner_if.source             corner_out
);
	import gcc_pkg::*;

	logic [2:0]       mask;
	logic [DW+PW-1:0] jm;
	logic [DW+PT_W-1:0] km;

	logic             v_s1, v_s2;
	logic [DW-1:0]    lx_s1;
	logic [PT_W-1:0]  jt_s1, kt_s1, base_s2;
	logic             bad_s1, bad_s2;

	logic             iv_q, ibad_q;
	logic [PT_W-1:0]  base_q;
	logic [2:0]       cnt_q, mask_q, cnt_nxt;
	logic [PT_W-1:0]  off, point;
	logic             ilast;

	logic             ov_q, olast_q, obad_q;
	logic [PT_W-1:0]  opt_q;

	logic             out_load, item_free, rdy2, rdy1;

	assign mask = {dim_z > PW'(1), dim_y > PW'(1), dim_x > PW'(1)};
	assign jm   = lo_y * dim_x;
	assign km   = lo_z * plane;

	// handshake chain back from the output register
	assign out_load  = !ov_q || corner_out.ready;
	assign ilast     = (cnt_q == mask_q);
	assign item_free = !iv_q || (out_load && ilast);
	assign rdy2      = !v_s2 || item_free;
	assign rdy1      = !v_s1 || rdy2;
	assign in_ready  = rdy1;

	always_comb begin
		off = '0;
		if (cnt_q[0])
			off = off + PT_W'(1);
		if (cnt_q[1])
			off = off + PT_W'(dim_x);
		if (cnt_q[2])
			off = off + plane;
		point   = ibad_q ? '0 : base_q + off;
		// next subset of the active axis bits
		cnt_nxt = ((cnt_q | ~mask_q) + 3'd1) & mask_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			iv_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (rdy1)
				v_s1 <= in_valid;
			if (rdy2)
				v_s2 <= v_s1;
			if (item_free)
				iv_q <= v_s2;
			if (out_load)
				ov_q <= iv_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			lx_s1  <= lo_x;
			jt_s1  <= PT_W'(jm);
			kt_s1  <= km[PT_W-1:0];
			bad_s1 <= bad;
		end
		if (rdy2) begin
			base_s2 <= PT_W'(lx_s1) + jt_s1 + kt_s1;
			bad_s2  <= bad_s1;
		end
		if (item_free) begin
			base_q <= base_s2;
			ibad_q <= bad_s2;
			mask_q <= bad_s2 ? 3'd0 : mask;
			cnt_q  <= 3'd0;
		end else if (out_load && iv_q) begin
			cnt_q <= cnt_nxt;
		end
		if (out_load) begin
			opt_q   <= point;
			olast_q <= ilast;
			obad_q  <= ibad_q;
		end
	end

	assign corner_out.valid       = ov_q;
	assign corner_out.point_index = opt_q;
	assign corner_out.last_corner = olast_q;
	assign corner_out.bad_cell    = obad_q;
endmodule

### rtl/core/grid_cell_corner_points_core.sv
// grid cell corner points: cell number in, corner point indices out
// path: divider, multiply and add stages, serialiser, output register
// throughput: one corner per cycle on the single output channel while it is not stalled;
// one cell per cycle in only for one-corner cells, as a cell gives 1, 2, 4 or 8 corners
// reset: arst_n clears all valid bits and sets every point count to one
module grid_cell_corner_points_core #(
	parameter int MAX_POINTS_PER_AXIS = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gcc_pkg::ADDR_W-1:0] paddr,
	input  logic [gcc_pkg::DATA_W-1:0] pwdata,
	output logic [gcc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	gcc_cell_if.sink                   cell_in,
	gcc_corner_if.source               corner_out
);
	import gcc_pkg::*;

	// point counts need PW bits, cell counts per axis (points - 1) need DW bits
	localparam int PW = $clog2(MAX_POINTS_PER_AXIS + 1);
	localparam int DW = $clog2(MAX_POINTS_PER_AXIS);

	logic [PW-1:0]   dim_x, dim_y, dim_z;
	logic [PT_W-1:0] plane;
	logic [DW-1:0]   d_x, d_y, d_z;
	logic [DW-1:0]   lo_x, lo_y, lo_z;
	logic            div_valid, div_ready, div_bad;

	// register file, also keeps the x*y plane size registered
	gcc_cfg #(
		.MAX_POINTS_PER_AXIS(MAX_POINTS_PER_AXIS),
		.PW(PW)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.dim_x(dim_x),
		.dim_y(dim_y),
		.dim_z(dim_z),
		.plane(plane)
	);

	// an inactive axis divides by one, giving position zero and passing the quotient on;
	// whatever quotient is left after z marks a cell beyond the grid
	assign d_x = (dim_x > PW'(1)) ? DW'(dim_x - PW'(1)) : DW'(1);
	assign d_y = (dim_y > PW'(1)) ? DW'(dim_y - PW'(1)) : DW'(1);
	assign d_z = (dim_z > PW'(1)) ? DW'(dim_z - PW'(1)) : DW'(1);

	// eighteen stage divider, five quotient bits per stage
	gcc_div #(
		.DW(DW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(cell_in.valid),
		.in_ready(cell_in.ready),
		.cell_no(cell_in.cell_number),
		.d_x(d_x),
		.d_y(d_y),
		.d_z(d_z),
		.out_valid(div_valid),
		.out_ready(div_ready),
		.lo_x(lo_x),
		.lo_y(lo_y),
		.lo_z(lo_z),
		.bad(div_bad)
	);

	// multiply and add stages, then the corner serialiser and output register
	gcc_corner #(
		.DW(DW),
		.PW(PW)
	) u_corner (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(div_valid),
		.in_ready(div_ready),
		.lo_x(lo_x),
		.lo_y(lo_y),
		.lo_z(lo_z),
		.bad(div_bad),
		.dim_x(dim_x),
		.dim_y(dim_y),
		.dim_z(dim_z),
		.plane(plane),
		.corner_out(corner_out)
	);
endmodule
